// ===== rtl/sfpa_pkg.sv =====
`default_nettype none
package sfpa_pkg;

   // opcodes
   localparam logic [3:0] OP_ADD = 4'd0;
   localparam logic [3:0] OP_SUB = 4'd1;
   localparam logic [3:0] OP_MUL = 4'd2;
   localparam logic [3:0] OP_DIV = 4'd3;
   localparam logic [3:0] OP_INC = 4'd4;
   localparam logic [3:0] OP_DEC = 4'd5;
   localparam logic [3:0] OP_MIN = 4'd6;
   localparam logic [3:0] OP_MAX = 4'd7;
   localparam logic [3:0] OP_I2F = 4'd8;
   localparam logic [3:0] OP_F2I = 4'd9;

   localparam logic signed [31:0] WORD_MAX = 32'sh7fff_ffff;
   localparam logic signed [31:0] WORD_MIN = 32'sh8000_0000;

   // one queued operation, classified by the front end
   typedef struct packed {
      logic [3:0]         opcode;
      logic signed [31:0] a;
      logic signed [31:0] b;
      logic               is_div;
   } entry_type;

   // per-stage control and non-divide result carried beside the divider
   typedef struct packed {
      logic        valid;
      logic        is_div;
      logic        neg;
      logic        dz;
      logic [31:0] res;
      logic        sat;
      logic        eq;
      logic        lt;
      logic        gt;
   } tag_type;

endpackage
`default_nettype wire

// ===== rtl/sfpa_front.sv =====
`default_nettype none
module sfpa_front (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 start,
   output logic                busy,
   input  wire  [3:0]          req_opcode,
   input  wire  signed [31:0]  req_operand_a,
   input  wire  signed [31:0]  req_operand_b,
   output logic                pop_valid,
   output sfpa_pkg::entry_type pop_entry
);

   sfpa_pkg::entry_type queue_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   sfpa_pkg::entry_type push_entry;

   // classify the incoming transfer
   always_comb begin
      push_entry.opcode = req_opcode;
      push_entry.a      = req_operand_a;
      push_entry.b      = req_operand_b;
      push_entry.is_div = (req_opcode == sfpa_pkg::OP_DIV);
   end

   assign busy      = (count_ff == 2'd2);
   assign push      = start && !busy;
   assign pop_valid = (count_ff != 2'd0);
   assign pop_entry = queue_ff[rd_ptr_ff];

   // pointers and fill count; the back end drains every cycle
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop_valid ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/sfpa_div.sv =====
`default_nettype none
module sfpa_div #(
   parameter int DW = 40
) (
   input  wire           clock,
   input  wire  [DW-1:0] dividend,
   input  wire  [31:0]   divisor,
   output logic [DW-1:0] quotient
);

   // restoring divider, one quotient bit per stage
   logic [DW-1:0] nq_ff  [DW];
   logic [31:0]   rem_ff [DW];
   logic [31:0]   dvs_ff [DW];

   for (genvar s = 0; s < DW; s++) begin : g_stage
      logic [DW-1:0] nq_prev;
      logic [31:0]   rem_prev;
      logic [31:0]   dvs_prev;
      logic [32:0]   shifted;
      logic [33:0]   diff;
      logic          ge;

      if (s == 0) begin : g_first
         assign nq_prev  = dividend;
         assign rem_prev = 32'd0;
         assign dvs_prev = divisor;
      end else begin : g_next
         assign nq_prev  = nq_ff[s-1];
         assign rem_prev = rem_ff[s-1];
         assign dvs_prev = dvs_ff[s-1];
      end

      always_comb begin
         shifted = {rem_prev, nq_prev[DW-1]};
         diff    = {1'b0, shifted} - {2'b00, dvs_prev};
         ge      = !diff[33];
      end

      always_ff @(posedge clock) begin
         rem_ff[s] <= ge ? diff[31:0] : shifted[31:0];
         nq_ff[s]  <= {nq_prev[DW-2:0], ge};
         dvs_ff[s] <= dvs_prev;
      end
   end

   assign quotient = nq_ff[DW-1];

endmodule
`default_nettype wire

// ===== rtl/sfpa_back.sv =====
`default_nettype none
module sfpa_back #(
   parameter int FRACTION_BITS = 8
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 in_valid,
   input  sfpa_pkg::entry_type in_entry,
   output logic                rsp_strobe,
   output logic signed [31:0]  rsp_result,
   output logic                rsp_equal,
   output logic                rsp_less,
   output logic                rsp_greater,
   output logic                rsp_saturated,
   output logic                rsp_divide_by_zero
);

   localparam int DW = 32 + FRACTION_BITS;
   localparam logic [DW-1:0] Q_MAX = DW'(33'h0_7fff_ffff);
   localparam logic [DW-1:0] Q_NEG = DW'(33'h0_8000_0000);
   localparam logic [31:0]   F_MASK = 32'((33'd1 << FRACTION_BITS) - 33'd1);

   // 33-bit add with clamp
   function automatic logic [32:0] sat_add(input logic signed [31:0] x,
                                           input logic signed [31:0] y,
                                           input logic sub);
      logic [32:0] s;
      logic        ovf;
      logic [31:0] r;
      s   = sub ? ({x[31], x} - {y[31], y}) : ({x[31], x} + {y[31], y});
      ovf = (s[32] != s[31]);
      r   = ovf ? (s[32] ? sfpa_pkg::WORD_MIN : sfpa_pkg::WORD_MAX) : s[31:0];
      return {ovf, r};
   endfunction

   // 64-bit clamp
   function automatic logic [32:0] clamp64(input logic signed [63:0] v);
      logic hi;
      logic lo;
      hi = (v > 64'sh0000_0000_7fff_ffff);
      lo = (v < -64'sh0000_0000_8000_0000);
      if (hi) return {1'b1, sfpa_pkg::WORD_MAX};
      if (lo) return {1'b1, sfpa_pkg::WORD_MIN};
      return {1'b0, v[31:0]};
   endfunction

   // first stage: everything but the multiply clamp and the divide
   logic        [32:0] nd_comb;
   logic signed [63:0] a_ext;
   logic signed [31:0] f2i;
   logic        [31:0] abs_a, abs_b;

   always_comb begin
      a_ext = {{32{in_entry.a[31]}}, in_entry.a};
      f2i   = in_entry.a >>> FRACTION_BITS;
      if (in_entry.a[31] && ((in_entry.a & F_MASK) != 32'd0)) begin
         f2i = f2i + 32'sd1;
      end
      abs_a = in_entry.a[31] ? (~in_entry.a + 32'd1) : in_entry.a;
      abs_b = in_entry.b[31] ? (~in_entry.b + 32'd1) : in_entry.b;
      case (in_entry.opcode)
         sfpa_pkg::OP_ADD: nd_comb = sat_add(in_entry.a, in_entry.b, 1'b0);
         sfpa_pkg::OP_SUB: nd_comb = sat_add(in_entry.a, in_entry.b, 1'b1);
         sfpa_pkg::OP_INC: nd_comb = sat_add(in_entry.a, 32'sd1, 1'b0);
         sfpa_pkg::OP_DEC: nd_comb = sat_add(in_entry.a, 32'sd1, 1'b1);
         sfpa_pkg::OP_MIN: nd_comb = {1'b0, (in_entry.a < in_entry.b) ? in_entry.a : in_entry.b};
         sfpa_pkg::OP_MAX: nd_comb = {1'b0, (in_entry.a > in_entry.b) ? in_entry.a : in_entry.b};
         sfpa_pkg::OP_I2F: nd_comb = clamp64(a_ext <<< FRACTION_BITS);
         sfpa_pkg::OP_F2I: nd_comb = {1'b0, f2i};
         default:          nd_comb = 33'd0;
      endcase
   end

   logic               v1_ff;
   logic               mul1_ff;
   logic               div1_ff;
   logic               neg1_ff;
   logic               dz1_ff;
   logic        [32:0] nd1_ff;
   logic signed [63:0] prod1_ff;
   logic        [DW-1:0] dvd1_ff;
   logic        [31:0] dvs1_ff;
   logic               eq1_ff, lt1_ff, gt1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      mul1_ff  <= (in_entry.opcode == sfpa_pkg::OP_MUL);
      div1_ff  <= in_entry.is_div;
      neg1_ff  <= in_entry.a[31] ^ in_entry.b[31];
      dz1_ff   <= in_entry.is_div && (in_entry.b == 32'sd0);
      nd1_ff   <= nd_comb;
      prod1_ff <= in_entry.a * in_entry.b;
      dvd1_ff  <= DW'(abs_a) << FRACTION_BITS;
      dvs1_ff  <= abs_b;
      eq1_ff   <= (in_entry.a == in_entry.b);
      lt1_ff   <= (in_entry.a < in_entry.b);
      gt1_ff   <= (in_entry.a > in_entry.b);
   end

   // second stage: multiply clamp, then the tag rides beside the divider
   sfpa_pkg::tag_type tag2;
   logic [32:0]       mul_clamped;

   always_comb begin
      mul_clamped  = clamp64(prod1_ff >>> FRACTION_BITS);
      tag2.valid   = v1_ff;
      tag2.is_div  = div1_ff && !dz1_ff;
      tag2.neg     = neg1_ff;
      tag2.dz      = dz1_ff;
      tag2.eq      = eq1_ff;
      tag2.lt      = lt1_ff;
      tag2.gt      = gt1_ff;
      if (dz1_ff) begin
         // b is zero, so the sign of a alone picks the limit
         tag2.sat = 1'b1;
         tag2.res = neg1_ff ? sfpa_pkg::WORD_MIN : sfpa_pkg::WORD_MAX;
      end else if (mul1_ff) begin
         tag2.sat = mul_clamped[32];
         tag2.res = mul_clamped[31:0];
      end else begin
         tag2.sat = nd1_ff[32];
         tag2.res = nd1_ff[31:0];
      end
   end

   logic [DW-1:0] quotient;

   sfpa_div #(.DW(DW)) u_div (
      .clock    (clock),
      .dividend (dvd1_ff),
      .divisor  (dvs1_ff),
      .quotient (quotient)
   );

   sfpa_pkg::tag_type line_ff [DW];

   // tag delay line, valid bits cleared at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DW; i++) begin
            line_ff[i].valid <= 1'b0;
         end
      end else begin
         line_ff[0].valid <= tag2.valid;
         for (int i = 1; i < DW; i++) begin
            line_ff[i].valid <= line_ff[i-1].valid;
         end
      end
      line_ff[0].is_div <= tag2.is_div;
      line_ff[0].neg    <= tag2.neg;
      line_ff[0].dz     <= tag2.dz;
      line_ff[0].res    <= tag2.res;
      line_ff[0].sat    <= tag2.sat;
      line_ff[0].eq     <= tag2.eq;
      line_ff[0].lt     <= tag2.lt;
      line_ff[0].gt     <= tag2.gt;
      for (int i = 1; i < DW; i++) begin
         line_ff[i].is_div <= line_ff[i-1].is_div;
         line_ff[i].neg    <= line_ff[i-1].neg;
         line_ff[i].dz     <= line_ff[i-1].dz;
         line_ff[i].res    <= line_ff[i-1].res;
         line_ff[i].sat    <= line_ff[i-1].sat;
         line_ff[i].eq     <= line_ff[i-1].eq;
         line_ff[i].lt     <= line_ff[i-1].lt;
         line_ff[i].gt     <= line_ff[i-1].gt;
      end
   end

   // output stage: sign and clamp the quotient
   sfpa_pkg::tag_type last;
   logic [31:0] res_in;
   logic        sat_in;

   always_comb begin
      last = line_ff[DW-1];
      res_in = last.res;
      sat_in = last.sat;
      if (last.is_div) begin
         if (last.neg) begin
            sat_in = (quotient > Q_NEG);
            res_in = sat_in ? sfpa_pkg::WORD_MIN : (~quotient[31:0] + 32'd1);
         end else begin
            sat_in = (quotient > Q_MAX);
            res_in = sat_in ? sfpa_pkg::WORD_MAX : quotient[31:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe <= 1'b0;
      end else begin
         rsp_strobe <= last.valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_result         <= res_in;
      rsp_saturated      <= sat_in;
      rsp_divide_by_zero <= last.dz;
      rsp_equal          <= last.eq;
      rsp_less           <= last.lt;
      rsp_greater        <= last.gt;
   end

   // checks
   a_dz_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_divide_by_zero |-> rsp_saturated)
      else $error("divide by zero without saturation");

   a_cmp_onehot: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $onehot({rsp_equal, rsp_less, rsp_greater}))
      else $error("compare flags not exclusive");

   a_sat_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_saturated |->
         (rsp_result == sfpa_pkg::WORD_MAX) || (rsp_result == sfpa_pkg::WORD_MIN))
      else $error("saturated result off the limits");

endmodule
`default_nettype wire

// ===== rtl/saturating_fixed_point_alu.sv =====
`default_nettype none
// Saturating fixed-point ALU on signed 32-bit words with FRACTION_BITS
// fraction bits.
// Request channel: an operation (req_opcode, req_operand_a, req_operand_b)
// transfers at a rising edge where start is high and busy is low.
// Response channel: each result appears on the rsp_ ports for one cycle
// with rsp_strobe high; the receiver cannot hold it off.
// Throughput: one operation per cycle, every opcode, divide included.
// Every opcode takes the same path, set by the restoring divider, which
// resolves one quotient bit per stage over 32 + FRACTION_BITS stages;
// other operations travel beside it so results leave in request order.
// A small queue separates the request side from the execution pipeline;
// since the pipeline never stalls the queue drains every cycle and busy
// stays low in normal use.
// Reset empties the queue and clears every pipeline valid bit; no
// result is strobed for an operation in flight at reset.
module saturating_fixed_point_alu #(
   parameter int FRACTION_BITS = 8
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                start,
   output logic               busy,
   input  wire  [3:0]         req_opcode,
   input  wire  signed [31:0] req_operand_a,
   input  wire  signed [31:0] req_operand_b,
   output logic               rsp_strobe,
   output logic signed [31:0] rsp_result,
   output logic               rsp_equal,
   output logic               rsp_less,
   output logic               rsp_greater,
   output logic               rsp_saturated,
   output logic               rsp_divide_by_zero
);

   logic                pop_valid;
   sfpa_pkg::entry_type pop_entry;

   // request queue
   sfpa_front u_front (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_opcode    (req_opcode),
      .req_operand_a (req_operand_a),
      .req_operand_b (req_operand_b),
      .pop_valid     (pop_valid),
      .pop_entry     (pop_entry)
   );

   // execution pipeline
   sfpa_back #(.FRACTION_BITS(FRACTION_BITS)) u_back (
      .clock              (clock),
      .reset              (reset),
      .in_valid           (pop_valid),
      .in_entry           (pop_entry),
      .rsp_strobe         (rsp_strobe),
      .rsp_result         (rsp_result),
      .rsp_equal          (rsp_equal),
      .rsp_less           (rsp_less),
      .rsp_greater        (rsp_greater),
      .rsp_saturated      (rsp_saturated),
      .rsp_divide_by_zero (rsp_divide_by_zero)
   );

endmodule
`default_nettype wire
